### rtl/ptt_pkg.sv
// shared types, constants and register codes for the peer timeslot tracker
`default_nettype none
package ptt_pkg;

   localparam int TABLE_ENTRIES_DEF = 8;
   localparam int SLOT_COUNT        = 64;

   localparam int TIME_W    = 32;
   localparam int DUR_W     = 16;
   localparam int SLOT_W    = 8;
   localparam int OFFS_W    = 25;
   localparam int CNT_OUT_W = 4;
   localparam int PROD_W    = SLOT_W + DUR_W;
   localparam int DIFF_W    = PROD_W + 2;
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_PERIOD   = 2'd0;
   localparam csr_index_type CSR_SLOT_DUR = 2'd1;
   localparam csr_index_type CSR_TIMEOUT  = 2'd2;

   localparam logic [DUR_W-1:0]  PERIOD_RST   = 16'd1000;
   localparam logic [DUR_W-1:0]  SLOT_DUR_RST = 16'd100;
   localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd10000;

   typedef struct packed {
      logic [TIME_W-1:0] packet_time;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] next_slot;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic signed [OFFS_W-1:0] time_offset;
      logic                     offset_valid;
      logic [CNT_OUT_W-1:0]     active_entries;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SELECT,
      ST_SCAN,
      ST_WRITE,
      ST_AGE,
      ST_WAIT_DIV,
      ST_OFFSET,
      ST_FIX,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

### rtl/ptt_if.sv
// valid/ready channel interfaces for request and response items
`default_nettype none
interface ptt_req_if;
   import ptt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ptt_rsp_if;
   import ptt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/peer_timeslot_tracker.sv
// Peer timeslot tracker top level.
// req_chan carries one received packet per item: packet time, slot, announced
// next slot and the current time. rsp_chan returns exactly one item per request:
// the peer frame offset, whether an offset is known, and the count of table
// entries in use. Registers (period, slot duration, entry timeout) are written
// through csr_wr_en / csr_index / csr_wdata; the user must write them only
// while the block is idle, as the block does not enforce it. One item is
// processed at a time. Each slot record that lies in the slot range walks the
// table once to find a hit, a free entry or the oldest entry, writes it, then
// walks it again to free stale entries through the one shared compare path; a
// record out of range is skipped, or for the next slot gets a count-only walk.
// A bit-serial remainder unit runs beside the walks. No new item is taken
// before the response of the last one has moved into the output register.
// Synchronous reset empties the table, clears the offset and restores the
// register defaults. When the receiver stalls, the response is held in the
// output register; the next item is still taken, and its response waits in the
// last step until the held one has left.
`default_nettype none
module peer_timeslot_tracker #(
   parameter int TABLE_ENTRIES = ptt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire ptt_pkg::csr_index_type              csr_index,
   input  wire logic [ptt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   ptt_req_if.sink                                  req_chan,
   ptt_rsp_if.source                                rsp_chan
);
   import ptt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   state_type state_ff, state_in;

   // configuration
   logic [DUR_W-1:0]  period_ff;
   logic [DUR_W-1:0]  slot_dur_ff;
   logic [TIME_W-1:0] timeout_ff;

   // table
   logic [TABLE_ENTRIES-1:0] entry_valid_ff;
   logic [SLOT_W-1:0]        entry_slot_ff [TABLE_ENTRIES];
   logic [TIME_W-1:0]        entry_seen_ff [TABLE_ENTRIES];

   // sequencer state
   req_type           item_ff;
   logic              rec_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              expire_ff;
   logic              hit_found_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic              free_found_ff;
   logic [IDX_W-1:0]  free_idx_ff;
   logic [TIME_W-1:0] min_seen_ff;
   logic [IDX_W-1:0]  min_idx_ff;
   logic [CNT_W-1:0]  cnt_ff;

   // remainder unit
   logic                 div_busy_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [TIME_W-1:0]    dvd_ff;
   logic [DUR_W-1:0]     rem_ff;

   // offset
   logic [PROD_W-1:0]        prod_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic [OFFS_W-1:0]        peer_offset_ff;
   logic                     offset_known_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // combinational
   logic                     req_accept;
   logic                     req_ready;
   logic                     out_load;
   logic [DUR_W-1:0]         per_eff;
   logic [SLOT_W-1:0]        cur_slot;
   logic                     cur_in_range;
   logic                     rd_valid;
   logic [SLOT_W-1:0]        rd_slot;
   logic [TIME_W-1:0]        rd_seen;
   logic                     last_idx;
   logic [TIME_W:0]          age_diff;
   logic                     expire_hit;
   logic [IDX_W-1:0]         pick_idx;
   logic [DUR_W:0]           div_trial;
   logic                     div_ge;
   logic [DUR_W:0]           rem_next;
   logic signed [DIFF_W-1:0] offset_sum;

   assign per_eff      = (period_ff == '0) ? DUR_W'(1) : period_ff;
   assign cur_slot     = rec_ff ? item_ff.next_slot : item_ff.slot;
   assign cur_in_range = cur_slot < SLOT_W'(SLOT_COUNT);
   assign rd_valid     = entry_valid_ff[idx_ff];
   assign rd_slot      = entry_slot_ff[idx_ff];
   assign rd_seen      = entry_seen_ff[idx_ff];
   assign last_idx     = idx_ff == IDX_W'(TABLE_ENTRIES - 1);

   // age taken as signed: an entry seen after now never expires
   assign age_diff   = {1'b0, item_ff.now_ms} - {1'b0, rd_seen};
   assign expire_hit = expire_ff && rd_valid && !age_diff[TIME_W]
                       && (age_diff[TIME_W-1:0] >= timeout_ff);

   assign pick_idx = hit_found_ff ? hit_idx_ff :
                     free_found_ff ? free_idx_ff : min_idx_ff;

   assign div_trial = {rem_ff, dvd_ff[TIME_W-1]};
   assign div_ge    = div_trial >= {1'b0, per_eff};
   assign rem_next  = div_ge ? (div_trial - {1'b0, per_eff}) : div_trial;

   assign offset_sum = diff_ff + $signed({{(DIFF_W-DUR_W){1'b0}}, per_eff});

   assign req_accept     = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            if (cur_in_range) state_in = ST_SCAN;
            else if (rec_ff) state_in = ST_AGE;
         end
         ST_SCAN: begin
            if (last_idx) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_AGE;
         ST_AGE: begin
            if (last_idx) state_in = rec_ff ? ST_WAIT_DIV : ST_SELECT;
         end
         ST_WAIT_DIV: begin
            if (!div_busy_ff) state_in = ST_OFFSET;
         end
         ST_OFFSET: state_in = ST_FIX;
         ST_FIX: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_OUT:  out_load  = !rsp_valid_ff || rsp_chan.ready;
         default: begin
            req_ready = 1'b0;
            out_load  = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         period_ff       <= PERIOD_RST;
         slot_dur_ff     <= SLOT_DUR_RST;
         timeout_ff      <= TIMEOUT_RST;
         entry_valid_ff  <= '0;
         offset_known_ff <= 1'b0;
         peer_offset_ff  <= '0;
         div_busy_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PERIOD:   period_ff   <= csr_wdata[DUR_W-1:0];
               CSR_SLOT_DUR: slot_dur_ff <= csr_wdata[DUR_W-1:0];
               CSR_TIMEOUT:  timeout_ff  <= csr_wdata[TIME_W-1:0];
               default: ;
            endcase
         end

         if (state_ff == ST_WRITE) entry_valid_ff[pick_idx] <= 1'b1;
         if (state_ff == ST_AGE && expire_hit) entry_valid_ff[idx_ff] <= 1'b0;

         if (req_accept) div_busy_ff <= 1'b1;
         else if (div_busy_ff && div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) div_busy_ff <= 1'b0;

         if (state_ff == ST_FIX && item_ff.packet_time != '0) begin
            offset_known_ff <= 1'b1;
            peer_offset_ff  <= diff_ff[DIFF_W-1] ? offset_sum[OFFS_W-1:0]
                                                 : diff_ff[OFFS_W-1:0];
         end

         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // remainder unit: one quotient bit per cycle, only the remainder is kept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         dvd_ff     <= req_chan.data.packet_time;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (div_busy_ff) begin
         dvd_ff     <= {dvd_ff[TIME_W-2:0], 1'b0};
         rem_ff     <= rem_next[DUR_W-1:0];
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // table sequencer datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_ff <= req_chan.data;
               rec_ff  <= 1'b0;
               prod_ff <= PROD_W'(req_chan.data.slot) * PROD_W'(slot_dur_ff);
            end
         end
         ST_SELECT: begin
            idx_ff        <= '0;
            hit_found_ff  <= 1'b0;
            free_found_ff <= 1'b0;
            if (!cur_in_range) begin
               if (!rec_ff) begin
                  rec_ff <= 1'b1;
               end else begin
                  // count-only pass when the next slot is not recorded
                  expire_ff <= 1'b0;
                  cnt_ff    <= '0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_valid && rd_slot == cur_slot && !hit_found_ff) begin
               hit_found_ff <= 1'b1;
               hit_idx_ff   <= idx_ff;
            end
            if (!rd_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= idx_ff;
            end
            if (idx_ff == '0 || rd_seen < min_seen_ff) begin
               min_seen_ff <= rd_seen;
               min_idx_ff  <= idx_ff;
            end
            idx_ff <= idx_ff + IDX_W'(1);
         end
         ST_WRITE: begin
            entry_slot_ff[pick_idx] <= cur_slot;
            entry_seen_ff[pick_idx] <= item_ff.now_ms;
            idx_ff    <= '0;
            cnt_ff    <= '0;
            expire_ff <= 1'b1;
         end
         ST_AGE: begin
            if (rd_valid && !expire_hit) cnt_ff <= cnt_ff + CNT_W'(1);
            idx_ff <= idx_ff + IDX_W'(1);
            if (last_idx && !rec_ff) rec_ff <= 1'b1;
         end
         ST_OFFSET: begin
            diff_ff <= $signed({2'b00, prod_ff})
                       - $signed({{(DIFF_W-DUR_W){1'b0}}, rem_ff})
                       - DIFF_W'(1);
         end
         default: ;
      endcase

      if (out_load) begin
         rsp_data_ff.time_offset    <= $signed(peer_offset_ff);
         rsp_data_ff.offset_valid   <= offset_known_ff;
         rsp_data_ff.active_entries <= CNT_OUT_W'(cnt_ff);
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> cnt_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count above table size");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> state_ff != ST_IDLE)
      else $error("remainder unit busy while idle");

   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |=> entry_valid_ff[$past(pick_idx)])
      else $error("written entry not marked valid");

   a_offset_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX && item_ff.packet_time != '0) |=> !peer_offset_ff[OFFS_W-1])
      else $error("peer offset negative after correction");

   a_hit_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE && hit_found_ff) |-> entry_slot_ff[hit_idx_ff] == cur_slot)
      else $error("hit entry holds another slot");
`endif

endmodule
`default_nettype wire
